// ----- design/krl_pkg.sv -----
// Shared types, codes and the microcode table of the keyed record list.
// Used by krl_seq, krl_dpath and keyed_record_list_top; no dependencies.
package krl_pkg;

    localparam int KRL_CAPACITY = 64;

    // Field widths of the streams.
    localparam int OP_W       = 2;
    localparam int KEY_W      = 31;
    localparam int SCORE_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 6;
    localparam int COUNT_W    = 7;
    localparam int IN_TDATA_W = 64;
    localparam int OUT_BITS_W = STATUS_W + POS_W + 3 * SCORE_W + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS_W + 7) / 8) * 8;
    localparam int ENTRY_W    = KEY_W + 3 * SCORE_W;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

    // Branch conditions.
    localparam logic [3:0] C_NEXT    = 4'd0;
    localparam logic [3:0] C_ALWAYS  = 4'd1;
    localparam logic [3:0] C_NACC    = 4'd2;
    localparam logic [3:0] C_OPC     = 4'd3;
    localparam logic [3:0] C_FULL    = 4'd4;
    localparam logic [3:0] C_EMPTY   = 4'd5;
    localparam logic [3:0] C_NDONE   = 4'd6;
    localparam logic [3:0] C_NHIT    = 4'd7;
    localparam logic [3:0] C_LOOKUP  = 4'd8;
    localparam logic [3:0] C_NOSHIFT = 4'd9;
    localparam logic [3:0] C_IDXLT   = 4'd10;
    localparam logic [3:0] C_OFREE   = 4'd11;

    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;
    localparam logic [1:0] CNT_CLR  = 2'd3;

    localparam logic [1:0] PSEL_ZERO  = 2'd0;
    localparam logic [1:0] PSEL_COUNT = 2'd1;
    localparam logic [1:0] PSEL_FOUND = 2'd2;

    // Program steps.
    localparam int UPC_W = 5;
    localparam logic [UPC_W-1:0] S_IDLE      = 5'd0;
    localparam logic [UPC_W-1:0] S_DISP      = 5'd1;
    localparam logic [UPC_W-1:0] S_JTAB      = 5'd2;
    localparam logic [UPC_W-1:0] S_J_REMOVE  = 5'd3;
    localparam logic [UPC_W-1:0] S_J_LOOKUP  = 5'd4;
    localparam logic [UPC_W-1:0] S_CLEAR     = 5'd5;
    localparam logic [UPC_W-1:0] S_APPEND    = 5'd6;
    localparam logic [UPC_W-1:0] S_APP_WR    = 5'd7;
    localparam logic [UPC_W-1:0] S_ERR_FULL  = 5'd8;
    localparam logic [UPC_W-1:0] S_SRCH_CHK  = 5'd9;
    localparam logic [UPC_W-1:0] S_SRCH_GO   = 5'd10;
    localparam logic [UPC_W-1:0] S_SRCH_LOOP = 5'd11;
    localparam logic [UPC_W-1:0] S_RESOLVE   = 5'd12;
    localparam logic [UPC_W-1:0] S_KIND      = 5'd13;
    localparam logic [UPC_W-1:0] S_SHIFT_GO  = 5'd14;
    localparam logic [UPC_W-1:0] S_SHIFT     = 5'd15;
    localparam logic [UPC_W-1:0] S_REM_OK    = 5'd16;
    localparam logic [UPC_W-1:0] S_ERR_EMPTY = 5'd17;
    localparam logic [UPC_W-1:0] S_ERR_MISS  = 5'd18;
    localparam logic [UPC_W-1:0] S_LOOK_OK   = 5'd19;
    localparam logic [UPC_W-1:0] S_FIN       = 5'd20;
    localparam logic [UPC_W-1:0] S_FIN_WAIT  = 5'd21;

    typedef struct packed {
        logic [3:0]          cond;
        logic [UPC_W-1:0]    target;
        logic                in_rdy;
        logic                rd_en;
        logic                idx_inc;
        logic                idx_ld_found;
        logic                wr_item;
        logic                wr_shift;
        logic                cmp_en;
        logic [1:0]          cnt_op;
        logic                res_ld;
        logic [STATUS_W-1:0] res_status;
        logic [1:0]          pos_sel;
        logic                sc_found;
        logic                out_ld;
    } krl_ctl_t;

    typedef struct packed {
        logic            in_valid;
        logic [OP_W-1:0] opcode;
        logic            full;
        logic            empty;
        logic            done;
        logic            hit;
        logic            lookup;
        logic            noshift;
        logic            idx_lt;
        logic            ofree;
    } krl_stat_t;

    localparam krl_ctl_t UC_NOP = '{
        cond: C_ALWAYS, target: S_IDLE, in_rdy: 1'b0, rd_en: 1'b0, idx_inc: 1'b0,
        idx_ld_found: 1'b0, wr_item: 1'b0, wr_shift: 1'b0, cmp_en: 1'b0,
        cnt_op: CNT_HOLD, res_ld: 1'b0, res_status: ST_OK, pos_sel: PSEL_ZERO,
        sc_found: 1'b0, out_ld: 1'b0
    };

    // The control store: one word per step.
    function automatic krl_ctl_t ucode(input logic [UPC_W-1:0] step);
        krl_ctl_t w;
        w = UC_NOP;
        case (step)
            S_IDLE: begin
                w.cond = C_NACC; w.target = S_IDLE; w.in_rdy = 1'b1;
            end
            S_DISP: begin
                w.cond = C_OPC; w.target = S_JTAB;
            end
            S_JTAB:     w.target = S_APPEND;
            S_J_REMOVE: w.target = S_SRCH_CHK;
            S_J_LOOKUP: w.target = S_SRCH_CHK;
            S_CLEAR: begin
                w.target = S_FIN; w.cnt_op = CNT_CLR; w.res_ld = 1'b1;
            end
            S_APPEND: begin
                w.cond = C_FULL; w.target = S_ERR_FULL;
            end
            S_APP_WR: begin
                w.target = S_FIN; w.wr_item = 1'b1; w.cnt_op = CNT_INC;
                w.res_ld = 1'b1; w.pos_sel = PSEL_COUNT;
            end
            S_ERR_FULL: begin
                w.target = S_FIN; w.res_ld = 1'b1; w.res_status = ST_FULL;
            end
            S_SRCH_CHK: begin
                w.cond = C_EMPTY; w.target = S_ERR_EMPTY;
            end
            S_SRCH_GO: begin
                w.cond = C_NEXT; w.rd_en = 1'b1; w.idx_inc = 1'b1;
            end
            S_SRCH_LOOP: begin
                w.cond = C_NDONE; w.target = S_SRCH_LOOP;
                w.rd_en = 1'b1; w.idx_inc = 1'b1; w.cmp_en = 1'b1;
            end
            S_RESOLVE: begin
                w.cond = C_NHIT; w.target = S_ERR_MISS;
            end
            S_KIND: begin
                w.cond = C_LOOKUP; w.target = S_LOOK_OK;
            end
            S_SHIFT_GO: begin
                w.cond = C_NOSHIFT; w.target = S_REM_OK; w.idx_ld_found = 1'b1;
            end
            S_SHIFT: begin
                w.cond = C_IDXLT; w.target = S_SHIFT;
                w.rd_en = 1'b1; w.idx_inc = 1'b1; w.wr_shift = 1'b1;
            end
            S_REM_OK: begin
                w.target = S_FIN; w.cnt_op = CNT_DEC; w.res_ld = 1'b1;
                w.pos_sel = PSEL_FOUND;
            end
            S_ERR_EMPTY: begin
                w.target = S_FIN; w.res_ld = 1'b1; w.res_status = ST_EMPTY;
            end
            S_ERR_MISS: begin
                w.target = S_FIN; w.res_ld = 1'b1; w.res_status = ST_MISS;
            end
            S_LOOK_OK: begin
                w.target = S_FIN; w.res_ld = 1'b1; w.pos_sel = PSEL_FOUND;
                w.sc_found = 1'b1;
            end
            S_FIN: begin
                w.cond = C_OFREE; w.target = S_IDLE; w.out_ld = 1'b1;
            end
            S_FIN_WAIT: w.target = S_FIN;
            default:    w = UC_NOP;
        endcase
        return w;
    endfunction

endpackage

// ----- design/krl_seq.sv -----
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on krl_pkg for the control word, status struct and program.
module krl_seq import krl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  krl_stat_t st,
    output krl_ctl_t  ctl
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             take;

    assign ctl = ucode(upc_reg);

    always_comb begin
        case (ctl.cond)
            C_NEXT:    take = 1'b0;
            C_ALWAYS:  take = 1'b1;
            C_NACC:    take = !st.in_valid;
            C_OPC:     take = 1'b1;
            C_FULL:    take = st.full;
            C_EMPTY:   take = st.empty;
            C_NDONE:   take = !st.done;
            C_NHIT:    take = !st.hit;
            C_LOOKUP:  take = st.lookup;
            C_NOSHIFT: take = st.noshift;
            C_IDXLT:   take = st.idx_lt;
            C_OFREE:   take = st.ofree;
            default:   take = 1'b0;
        endcase
        if (!take) begin
            upc_next = upc_reg + UPC_W'(1);
        end else if (ctl.cond == C_OPC) begin
            // Jump table indexed by the operation code.
            upc_next = ctl.target + UPC_W'(st.opcode);
        end else begin
            upc_next = ctl.target;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= S_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ----- design/krl_dpath.sv -----
// Datapath of the keyed record list: record memory, count, scan index,
// key compare, result registers and output register. Uses krl_pkg.
module krl_dpath import krl_pkg::*; #(
    parameter int CAPACITY = KRL_CAPACITY
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  krl_ctl_t               ctl,
    output krl_stat_t              st
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [ENTRY_W-1:0] mem [CAPACITY];

    logic [OP_W-1:0]    op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [3*SCORE_W-1:0] sc_reg;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          rd_vld_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic          hit_reg;
    logic [AW-1:0] found_idx_reg;
    logic [3*SCORE_W-1:0] found_sc_reg;

    logic [STATUS_W-1:0]  res_status_reg;
    logic [POS_W-1:0]     res_pos_reg;
    logic [3*SCORE_W-1:0] res_sc_reg;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic          acc;
    logic          idx_lt;
    logic          rd_fire;
    logic          match;
    logic          last;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic          ofree;
    logic          out_ld;

    assign s_tready = ctl.in_rdy;
    assign acc      = s_tvalid & ctl.in_rdy;
    assign idx_lt   = idx_reg < cnt_reg;
    // Reads stop at the fill count, so the address never leaves the written range.
    assign rd_fire  = ctl.rd_en & idx_lt;
    assign match    = rd_vld_reg && (rd_data_reg[ENTRY_W-1:3*SCORE_W] == key_reg);
    assign last     = rd_vld_reg && ((CW'(rd_idx_reg) + CW'(1)) == cnt_reg);
    assign ofree    = !m_tvalid_reg || m_tready;
    assign out_ld   = ctl.out_ld & ofree;

    assign st.in_valid = s_tvalid;
    assign st.opcode   = op_reg;
    assign st.full     = cnt_reg == CAP_C;
    assign st.empty    = cnt_reg == '0;
    assign st.done     = match || last;
    assign st.hit      = hit_reg;
    assign st.lookup   = op_reg == OP_LOOKUP;
    assign st.noshift  = (CW'(found_idx_reg) + CW'(1)) == cnt_reg;
    assign st.idx_lt   = idx_lt;
    assign st.ofree    = ofree;

    // Append writes at the fill count; the shift writes each entry one place lower.
    always_comb begin
        wr_en   = ctl.wr_item | (ctl.wr_shift & rd_vld_reg);
        if (ctl.wr_item) begin
            wr_addr = cnt_reg[AW-1:0];
            wr_data = {key_reg, sc_reg};
        end else begin
            wr_addr = rd_idx_reg - AW'(1);
            wr_data = rd_data_reg;
        end
    end

    always_comb begin
        case (ctl.cnt_op)
            CNT_INC: cnt_next = cnt_reg + CW'(1);
            CNT_DEC: cnt_next = cnt_reg - CW'(1);
            CNT_CLR: cnt_next = '0;
            default: cnt_next = cnt_reg;
        endcase
        if (acc) begin
            idx_next = '0;
        end else if (ctl.idx_ld_found) begin
            idx_next = CW'(found_idx_reg) + CW'(1);
        end else if (ctl.idx_inc && idx_lt) begin
            idx_next = idx_reg + CW'(1);
        end else begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_fire) begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
            rd_idx_reg  <= idx_reg[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            rd_vld_reg <= rd_fire;
            if (acc) begin
                hit_reg <= 1'b0;
            end else if (ctl.cmp_en && match) begin
                hit_reg <= 1'b1;
            end
            if (out_ld) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            op_reg  <= s_tdata[OP_W-1:0];
            key_reg <= s_tdata[OP_W+KEY_W-1:OP_W];
            sc_reg  <= s_tdata[OP_W+KEY_W+3*SCORE_W-1:OP_W+KEY_W];
        end
        if (ctl.cmp_en && match) begin
            found_idx_reg <= rd_idx_reg;
            found_sc_reg  <= rd_data_reg[3*SCORE_W-1:0];
        end
        if (ctl.res_ld) begin
            res_status_reg <= ctl.res_status;
            case (ctl.pos_sel)
                PSEL_COUNT: res_pos_reg <= POS_W'(cnt_reg);
                PSEL_FOUND: res_pos_reg <= POS_W'(found_idx_reg);
                default:    res_pos_reg <= '0;
            endcase
            res_sc_reg <= ctl.sc_found ? found_sc_reg : '0;
        end
        if (out_ld) begin
            m_tdata_reg <= OUT_TDATA_W'({COUNT_W'(cnt_reg), res_sc_reg,
                                         res_pos_reg, res_status_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- design/keyed_record_list_top.sv -----
// Keyed record list: a list of records (key and three scores) in insertion
// order with append, remove by key, lookup by key and clear.
//
// The s_ stream carries one command item; the m_ stream returns exactly one
// result item per command, in order. A small microprogram steps a plain
// datapath: one record memory port each for read and write, one key compare.
// The record memory's single read port sets the scan rate of one entry per
// cycle for both the search and the shift-down after a remove.
// A new item is taken only when the program is back at its idle step, in the
// cycle after the previous result was loaded into the output register; the
// result may still wait there for the receiver. A stalled receiver holds the
// program in its final steps once a second result is ready.
// Reset empties the list (count zero) and drops any pending result; the
// memory contents are not cleared, since only entries below the count are
// ever read.
module keyed_record_list_top import krl_pkg::*; #(
    parameter int CAPACITY = KRL_CAPACITY
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // operation[1:0], record_key[32:2], score_a[42:33], score_b[52:43],
    // score_c[62:53], zero[63]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status[1:0], position[7:2], found_a[17:8], found_b[27:18],
    // found_c[37:28], entry_count[44:38], zero[47:45]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    krl_ctl_t  ctl;
    krl_stat_t st;

    krl_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .ctl     (ctl)
    );

    krl_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .ctl      (ctl),
        .st       (st)
    );

endmodule
